// ===== rtl/core/dmx_pkg.sv =====
package dmx_pkg;

  // Fixed widths of the item fields and registers.
  localparam int SLOT_W  = 10;
  localparam int LEVEL_W = 8;
  localparam int CMD_W   = 3;
  localparam int TICK_W  = 16;
  localparam int BIT_W   = 4;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  // Serial frame: start bit, eight data bits, two stop bits.
  localparam logic [BIT_W-1:0] DATA_LAST_BIT = 4'd8;
  localparam logic [BIT_W-1:0] FRAME_BITS    = 4'd11;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_START = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    PH_OFF   = 2'd0,
    PH_BREAK = 2'd1,
    PH_MAB   = 2'd2,
    PH_TX    = 2'd3
  } phase_t;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_CODE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_BREAK_TICKS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAB_TICKS     = 3'd3;
  localparam logic [IDX_W-1:0] REG_BIT_TICKS     = 3'd4;

  // Requests from the sequencer to the universe store.
  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  addr;
    logic [LEVEL_W-1:0] data;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               clear;
    logic [LEVEL_W-1:0] fill;
  } store_ctl_t;

  // Level driven on the line for a given sequencer state.
  function automatic logic line_of(phase_t ph, logic [BIT_W-1:0] bi, logic b0);
    logic l;
    l = 1'b1;
    if (ph == PH_BREAK) begin
      l = 1'b0;
    end else if (ph == PH_TX) begin
      if (bi == '0) begin
        l = 1'b0;
      end else if (bi <= DATA_LAST_BIT) begin
        l = b0;
      end
    end
    return l;
  endfunction

endpackage

// ===== rtl/core/dmx_store.sv =====
module dmx_store import dmx_pkg::*; #(
  parameter int MAX_SLOTS = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  store_ctl_t         ctl,
  output logic [LEVEL_W-1:0] rd_data,
  output logic               busy
);

  localparam int AW = (MAX_SLOTS < 2) ? 1 : $clog2(MAX_SLOTS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS);

  logic [LEVEL_W-1:0] mem [0:MAX_SLOTS];
  logic [LEVEL_W-1:0] rd_data_r;
  logic               busy_r;
  logic [AW-1:0]      cnt_r;
  logic [LEVEL_W-1:0] fill_r;

  // Sweep control: runs after reset and on a clear request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      fill_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == LAST_ADDR) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end else if (ctl.clear) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      fill_r <= ctl.fill;
    end
  end

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[cnt_r] <= (cnt_r == '0) ? fill_r : '0;
    end else if (ctl.we) begin
      mem[ctl.addr[AW-1:0]] <= ctl.data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// ===== rtl/core/dmx512_frame_transmitter_core.sv =====
// Result: each item's result is registered and shows in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; a tick that starts a new slot
// waits in a load state for the universe store read, and a clear command holds the input while
// the store sweep rewrites every slot.
// Reset: synchronous, active low; the line goes idle at mark, registers take their defaults,
// and the store sweep zeroes the store before the first item is taken.
module dmx512_frame_transmitter_core import dmx_pkg::*; #(
  parameter int MAX_SLOTS = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input items.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // slot [9:0], slot_value [17:10], zero fill
  input  logic [CMD_W-1:0]  in_tuser,   // command [2:0]
  // Result items.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // line_level [0], phase [2:1], zero fill
  output logic              out_tlast,  // frame_done
  // Configuration writes.
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int SW = (MAX_SLOTS < 2) ? 1 : $clog2(MAX_SLOTS + 1);
  localparam logic [SLOT_W-1:0] MAX_SLOT_V = SLOT_W'(MAX_SLOTS);

  typedef enum logic [1:0] {
    S_READY = 2'b01,
    S_LOAD  = 2'b10
  } seq_state_t;

  seq_state_t         state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [LEVEL_W-1:0] shift_r, shift_nxt;
  logic               stop_r, stop_nxt;

  logic [SLOT_W-1:0]  ch_cnt_r;
  logic [LEVEL_W-1:0] start_code_r;
  logic [TICK_W-1:0]  brk_ticks_r;
  logic [TICK_W-1:0]  mab_ticks_r;
  logic [7:0]         bit_ticks_r;

  logic               out_valid_r;
  logic               out_line_r;
  phase_t             out_phase_r;
  logic               out_done_r;

  cmd_t               cmd;
  logic [SLOT_W-1:0]  in_slot;
  logic [LEVEL_W-1:0] in_value;
  logic               acc;
  logic               load_req;
  logic [SW-1:0]      load_addr;
  logic               done;
  logic               res_line;
  phase_t             res_phase;
  logic [TICK_W-1:0]  tick_inc;
  logic [BIT_W-1:0]   bit_inc;
  logic [SLOT_W-1:0]  last_slot;
  store_ctl_t         ctl;
  logic [LEVEL_W-1:0] rd_data;
  logic               store_busy;

  assign cmd      = cmd_t'(in_tuser);
  assign in_slot  = in_tdata[9:0];
  assign in_value = in_tdata[17:10];

  assign in_tready = (state_r == S_READY) && !store_busy && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  assign tick_inc  = tick_r + 1'b1;
  assign bit_inc   = bit_r + 1'b1;
  assign last_slot = (ch_cnt_r > MAX_SLOT_V) ? MAX_SLOT_V : ch_cnt_r;

  // Command decode and sequencer step.
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    slot_nxt  = slot_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    stop_nxt  = stop_r;
    load_req  = 1'b0;
    load_addr = '0;
    done      = 1'b0;
    case (cmd)
      CMD_TICK: begin
        case (phase_r)
          PH_BREAK: begin
            if (tick_inc >= brk_ticks_r || tick_inc == '0) begin
              phase_nxt = PH_MAB;
              tick_nxt  = '0;
            end else begin
              tick_nxt = tick_inc;
            end
          end
          PH_MAB: begin
            if (tick_inc >= mab_ticks_r || tick_inc == '0) begin
              phase_nxt = PH_TX;
              tick_nxt  = '0;
              slot_nxt  = '0;
              bit_nxt   = '0;
              load_req  = 1'b1;
              load_addr = '0;
            end else begin
              tick_nxt = tick_inc;
            end
          end
          PH_TX: begin
            if (tick_inc < TICK_W'(bit_ticks_r)) begin
              tick_nxt = tick_inc;
            end else begin
              tick_nxt = '0;
              if (bit_r != '0 && bit_r <= DATA_LAST_BIT) begin
                shift_nxt = shift_r >> 1;
              end
              if (bit_inc < FRAME_BITS) begin
                bit_nxt = bit_inc;
              end else if (SLOT_W'(slot_r) < last_slot) begin
                slot_nxt  = slot_r + 1'b1;
                bit_nxt   = '0;
                load_req  = 1'b1;
                load_addr = slot_r + 1'b1;
              end else begin
                // End of the frame: back to break, or off when a stop waits.
                bit_nxt   = '0;
                slot_nxt  = '0;
                shift_nxt = '0;
                done      = 1'b1;
                stop_nxt  = 1'b0;
                phase_nxt = stop_r ? PH_OFF : PH_BREAK;
              end
            end
          end
          default: begin
          end
        endcase
      end
      CMD_START: begin
        phase_nxt = PH_BREAK;
        tick_nxt  = '0;
        slot_nxt  = '0;
        bit_nxt   = '0;
        shift_nxt = '0;
        stop_nxt  = 1'b0;
      end
      CMD_STOP: begin
        if (phase_r == PH_TX) begin
          stop_nxt = 1'b1;
        end else begin
          phase_nxt = PH_OFF;
          tick_nxt  = '0;
          stop_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // A tick reports the line before its step, any other command after its action.
  always_comb begin
    if (cmd == CMD_TICK) begin
      res_line  = line_of(phase_r, bit_r, shift_r[0]);
      res_phase = phase_r;
    end else begin
      res_line  = line_of(phase_nxt, bit_nxt, shift_nxt[0]);
      res_phase = phase_nxt;
    end
  end

  // Store requests.
  always_comb begin
    ctl.we      = acc && (cmd == CMD_WRITE) && (in_slot <= MAX_SLOT_V);
    ctl.addr    = in_slot;
    ctl.data    = in_value;
    ctl.rd_en   = acc && load_req;
    ctl.rd_addr = SLOT_W'(load_addr);
    ctl.clear   = acc && (cmd == CMD_CLEAR);
    ctl.fill    = start_code_r;
  end

  dmx_store #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_data (rd_data),
    .busy    (store_busy)
  );

  // A tick that starts a slot waits in the load state for the store read.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_READY: if (acc && load_req) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_READY;
      default: state_nxt = S_READY;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_READY;
      phase_r <= PH_OFF;
      tick_r  <= '0;
      slot_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      stop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LOAD) begin
        shift_r <= rd_data;
      end else if (acc) begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        slot_r  <= slot_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r     <= 10'd512;
      start_code_r <= 8'd0;
      brk_ticks_r  <= 16'd176;
      mab_ticks_r  <= 16'd12;
      bit_ticks_r  <= 8'd4;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: ch_cnt_r     <= cfg_wdata[SLOT_W-1:0];
        REG_START_CODE:    start_code_r <= cfg_wdata[LEVEL_W-1:0];
        REG_BREAK_TICKS:   brk_ticks_r  <= cfg_wdata;
        REG_MAB_TICKS:     mab_ticks_r  <= cfg_wdata;
        REG_BIT_TICKS:     bit_ticks_r  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_line_r  <= res_line;
      out_phase_r <= res_phase;
      out_done_r  <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_phase_r, out_line_r};
  assign out_tlast  = out_done_r;

  // A frame only ends from the transmit phase.
  a_done_in_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_phase_r == PH_TX))
    else $error("frame end reported outside transmit phase");

  // A slot load always goes through the read wait state.
  a_load_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && load_req) |=> (state_r == S_LOAD && !in_tready))
    else $error("slot load did not wait for the store read");

  // No stop can be left pending once the line is off.
  a_off_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_OFF) |-> !stop_r)
    else $error("stop pending while off");

  // Bit position stays inside the frame.
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TX) |-> (bit_r < FRAME_BITS))
    else $error("bit index beyond the frame");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import dmx_pkg::*;

  localparam int MAX_SLOTS      = 512;
  localparam int UNIVERSE_DEPTH = MAX_SLOTS + 1;
  localparam int DIRECTED_ROWS  = 23;
  localparam int RUNS           = 7;
  // Command codes past the clear command are reserved; the block treats them as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;

  // One result item as seen on the line.
  typedef struct packed {
    logic   line;
    phase_t ph;
    logic   done;
  } line_item_t;

  // One row of the directed table; typed rows carry a hand-written expectation.
  typedef struct packed {
    logic              typed;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        level;
    line_item_t        res;
  } dir_row_t;

  // Register setting and item budget for one random run.
  typedef struct packed {
    logic [15:0] chan;
    logic [15:0] code;
    logic [15:0] brk;
    logic [15:0] mab;
    logic [15:0] bits;
    int          items;
    bit          soak;
    bit          calm;
  } run_cfg_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata   = '0;
  logic [CMD_W-1:0]  in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic              cfg_wr_en  = 1'b0;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]  cfg_wdata  = '0;

  dmx512_frame_transmitter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow of the transmitter: universe, sequencer state and registers.
  logic [7:0]        universe [UNIVERSE_DEPTH];
  phase_t            ph_q;
  logic [TICK_W-1:0] tick_q;
  logic [SLOT_W-1:0] slot_q;
  logic [BIT_W-1:0]  bit_q;
  logic [7:0]        shift_q;
  logic              stop_q;
  logic [9:0]        chan_r;
  logic [7:0]        code_r;
  logic [15:0]       brk_r;
  logic [15:0]       mab_r;
  logic [7:0]        bits_r;

  line_item_t line_expect_q [$];
  int         mismatches = 0;
  int         gap_pct    = 0;
  int         stall_pct  = 0;
  int         stall_left = 0;
  bit         calm       = 1'b0;

  dir_row_t directed_rows [DIRECTED_ROWS];
  run_cfg_t runs [RUNS];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Level on the line for the current sequencer state.
  function automatic logic line_now();
    if (ph_q == PH_BREAK) return 1'b0;
    if (ph_q == PH_TX) begin
      if (bit_q == '0) return 1'b0;
      if (bit_q <= DATA_LAST_BIT) return shift_q[0];
    end
    return 1'b1;
  endfunction

  function automatic void load_slot(logic [SLOT_W-1:0] idx);
    slot_q  = idx;
    bit_q   = '0;
    tick_q  = '0;
    shift_q = (idx < UNIVERSE_DEPTH) ? universe[idx] : 8'd0;
  endfunction

  // Step the sequencer by one tick; true when the last slot's stop bits end.
  function automatic logic advance_tick();
    logic [9:0] top_slot;
    if (ph_q == PH_OFF) return 1'b0;
    tick_q = tick_q + 1'b1;
    if (ph_q == PH_BREAK) begin
      if (tick_q >= brk_r || tick_q == '0) begin
        ph_q   = PH_MAB;
        tick_q = '0;
      end
      return 1'b0;
    end
    if (ph_q == PH_MAB) begin
      if (tick_q >= mab_r || tick_q == '0) begin
        ph_q = PH_TX;
        load_slot('0);
      end
      return 1'b0;
    end
    if (tick_q < {8'd0, bits_r}) return 1'b0;
    tick_q = '0;
    if (bit_q >= 4'd1 && bit_q <= DATA_LAST_BIT) shift_q = shift_q >> 1;
    bit_q = bit_q + 1'b1;
    if (bit_q < FRAME_BITS) return 1'b0;
    top_slot = (chan_r > MAX_SLOTS) ? 10'(MAX_SLOTS) : chan_r;
    if (slot_q < top_slot) begin
      load_slot(slot_q + 1'b1);
      return 1'b0;
    end
    bit_q   = '0;
    slot_q  = '0;
    shift_q = '0;
    if (stop_q) begin
      stop_q = 1'b0;
      ph_q   = PH_OFF;
    end else begin
      ph_q = PH_BREAK;
    end
    return 1'b1;
  endfunction

  // Apply one command to the shadow and return the line it reports.
  function automatic line_item_t predict_line(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
                                              logic [7:0] v);
    line_item_t r;
    r.done = 1'b0;
    if (c == CMD_TICK) begin
      r.line = line_now();
      r.ph   = ph_q;
      r.done = advance_tick();
      return r;
    end
    case (c)
      CMD_WRITE: begin
        if (s < UNIVERSE_DEPTH) universe[s] = v;
      end
      CMD_START: begin
        ph_q    = PH_BREAK;
        tick_q  = '0;
        slot_q  = '0;
        bit_q   = '0;
        shift_q = '0;
        stop_q  = 1'b0;
      end
      CMD_STOP: begin
        if (ph_q == PH_TX) begin
          stop_q = 1'b1;
        end else begin
          ph_q   = PH_OFF;
          tick_q = '0;
          stop_q = 1'b0;
        end
      end
      CMD_CLEAR: begin
        for (int i = 1; i < UNIVERSE_DEPTH; i++) universe[i] = 8'd0;
        universe[0] = code_r;
      end
      default: ;
    endcase
    r.line = line_now();
    r.ph   = ph_q;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input line_item_t want, input line_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t: expected line %0b phase %0d done %0b,", what, $time,
               want.line, want.ph, want.done);
      $display("  got line %0b phase %0d done %0b", got.line, got.ph, got.done);
    end
  endtask

  // Offer one item, wait for it to be taken, then record what it should report.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
                           input logic [7:0] v, input logic typed, input line_item_t typed_res);
    line_item_t pr;
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {6'd0, v, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pr = predict_line(c, s, v);
    line_expect_q.push_back(typed ? typed_res : pr);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // One register write; the shadow copy follows it at once.
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CHANNEL_COUNT: chan_r = val[9:0];
      REG_START_CODE:    code_r = val[7:0];
      REG_BREAK_TICKS:   brk_r  = val;
      REG_MAB_TICKS:     mab_r  = val;
      REG_BIT_TICKS:     bits_r = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver side: random stall bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    line_item_t got;
    line_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.line = out_tdata[0];
      got.ph   = phase_t'(out_tdata[2:1]);
      got.done = out_tlast;
      if (line_expect_q.size() == 0) begin
        flag_mismatch("no item pending", '0, got);
      end else begin
        want = line_expect_q.pop_front();
        if (got.line !== want.line || got.ph !== want.ph || got.done !== want.done) begin
          flag_mismatch("field", want, got);
        end
      end
    end
  end

  initial begin
    logic [CMD_W-1:0]  c;
    logic [SLOT_W-1:0] s;
    logic [7:0]        v;
    int                r;
    int                sel;

    // Directed items against the reset registers: 512 channels, break 176, mab 12, 4 ticks.
    directed_rows = '{
      '{1'b1, CMD_TICK,  10'd0,    8'h00, '{1'b1, PH_OFF,   1'b0}},
      '{1'b1, CMD_WRITE, 10'd0,    8'hFF, '{1'b1, PH_OFF,   1'b0}},
      '{1'b1, CMD_WRITE, 10'd512,  8'h80, '{1'b1, PH_OFF,   1'b0}},
      '{1'b1, CMD_WRITE, 10'd1023, 8'h55, '{1'b1, PH_OFF,   1'b0}},
      '{1'b1, CMD_WRITE, 10'd513,  8'hAA, '{1'b1, PH_OFF,   1'b0}},
      '{1'b1, CMD_SPARE_FIRST,        10'h3FF, 8'hFF, '{1'b1, PH_OFF, 1'b0}},
      '{1'b1, CMD_SPARE_FIRST + 3'd1, 10'h155, 8'h5A, '{1'b1, PH_OFF, 1'b0}},
      '{1'b1, CMD_SPARE_FIRST + 3'd2, 10'h2AA, 8'hA5, '{1'b1, PH_OFF, 1'b0}},
      '{1'b1, CMD_STOP,  10'd0,    8'h00, '{1'b1, PH_OFF,   1'b0}},
      '{1'b1, CMD_START, 10'd0,    8'h00, '{1'b0, PH_BREAK, 1'b0}},
      '{1'b1, CMD_TICK,  10'd0,    8'h00, '{1'b0, PH_BREAK, 1'b0}},
      '{1'b1, CMD_TICK,  10'h3FF,  8'hFF, '{1'b0, PH_BREAK, 1'b0}},
      '{1'b1, CMD_STOP,  10'd0,    8'h00, '{1'b1, PH_OFF,   1'b0}},
      '{1'b1, CMD_TICK,  10'd0,    8'h00, '{1'b1, PH_OFF,   1'b0}},
      '{1'b1, CMD_START, 10'd0,    8'h00, '{1'b0, PH_BREAK, 1'b0}},
      '{1'b1, CMD_START, 10'd0,    8'h00, '{1'b0, PH_BREAK, 1'b0}},
      '{1'b1, CMD_CLEAR, 10'd0,    8'h00, '{1'b0, PH_BREAK, 1'b0}},
      '{1'b1, CMD_WRITE, 10'd1,    8'h01, '{1'b0, PH_BREAK, 1'b0}},
      '{1'b0, CMD_TICK,  10'd0,    8'h00, '{1'b0, PH_OFF,   1'b0}},
      '{1'b0, CMD_TICK,  10'd0,    8'h00, '{1'b0, PH_OFF,   1'b0}},
      '{1'b0, CMD_WRITE, 10'd512,  8'h7E, '{1'b0, PH_OFF,   1'b0}},
      '{1'b1, CMD_STOP,  10'd0,    8'h00, '{1'b1, PH_OFF,   1'b0}},
      '{1'b1, CMD_CLEAR, 10'd0,    8'h00, '{1'b1, PH_OFF,   1'b0}}
    };

    // Register settings per run: small frames mostly, with two tick-heavy soak runs.
    // Upper bits of the wide write data must be dropped by the narrow registers.
    runs = '{
      '{16'h0001, 16'h00FF, 16'h0001, 16'h0001, 16'h0001, 250, 1'b0, 1'b0},
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 200, 1'b0, 1'b0},
      '{16'hFC03, 16'hA35A, 16'h0003, 16'h0002, 16'h0102, 250, 1'b0, 1'b0},
      '{16'hFFFF, 16'h00C3, 16'h0001, 16'h0001, 16'h0001, 250, 1'b1, 1'b0},
      '{16'h0000, 16'h0011, 16'hFFFF, 16'hFFFF, 16'h00FF, 100, 1'b1, 1'b0},
      '{16'h0002, 16'h003C, 16'h0005, 16'h0004, 16'h0003, 300, 1'b0, 1'b0},
      '{16'h0004, 16'h0096, 16'h0002, 16'h0003, 16'h0002, 250, 1'b0, 1'b1}
    };

    // Shadow state after reset.
    for (int i = 0; i < UNIVERSE_DEPTH; i++) universe[i] = 8'd0;
    ph_q    = PH_OFF;
    tick_q  = '0;
    slot_q  = '0;
    bit_q   = '0;
    shift_q = '0;
    stop_q  = 1'b0;
    chan_r  = 10'd512;
    code_r  = 8'd0;
    brk_r   = 16'd176;
    mab_r   = 16'd12;
    bits_r  = 8'd4;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed_rows[i].cmd, directed_rows[i].slot, directed_rows[i].level,
                directed_rows[i].typed, directed_rows[i].res);
    end

    for (int k = 0; k < RUNS; k++) begin
      // Hold off until the block has drained, then load the run's registers.
      in_tvalid <= 1'b0;
      while (line_expect_q.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      cfg_write(REG_CHANNEL_COUNT, runs[k].chan);
      cfg_write(REG_START_CODE, runs[k].code);
      cfg_write(REG_BREAK_TICKS, runs[k].brk);
      cfg_write(REG_MAB_TICKS, runs[k].mab);
      cfg_write(REG_BIT_TICKS, runs[k].bits);
      cfg_wr_en <= 1'b0;
      calm      = runs[k].calm;
      gap_pct   = runs[k].calm ? 0 : 15;
      stall_pct = runs[k].calm ? 0 : 15;

      // Each run opens with a start; soak runs are almost all ticks.
      for (int n = 0; n < runs[k].items; n++) begin
        sel = $urandom_range(0, 99);
        r   = $urandom_range(0, 9);
        s   = (r < 8) ? SLOT_W'($urandom_range(0, MAX_SLOTS)) : SLOT_W'($urandom);
        v   = 8'($urandom);
        if (n == 0) begin
          c = CMD_START;
        end else if (runs[k].soak) begin
          c = (sel < 96) ? CMD_TICK : CMD_WRITE;
        end else if (sel < 78) begin
          c = CMD_TICK;
        end else if (sel < 88) begin
          c = CMD_WRITE;
        end else if (sel < 92) begin
          c = CMD_START;
        end else if (sel < 96) begin
          c = CMD_STOP;
        end else if (sel < 98) begin
          c = CMD_CLEAR;
        end else begin
          c = CMD_SPARE_FIRST + 3'($urandom_range(0, 2));
        end
        send_item(c, s, v, 1'b0, '0);
      end
    end

    // Let every pending result come out, then report.
    in_tvalid <= 1'b0;
    while (line_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
